@@ hw/rtl/icds_pkg.sv @@
`timescale 1ns / 1ps
package icds_pkg;

  // Number of divisor bases, shift steps and candidate divisors.
  localparam int NUM_A = 8;
  localparam int NUM_G = 8;
  localparam int NUM_CAND = NUM_A * NUM_G;

  // Reset value of the source clock register.
  localparam logic [31:0] CLK_RESET = 32'd199999998;

  // Divider code reported when no candidate fits.
  localparam logic [5:0] NOFIT_CODE = 6'h31;

  // Largest target divider.
  localparam logic [15:0] DIV_LIMIT = 16'hFFFF;

  // The filter is 5*(clk/1000)/100000, which equals clk/20000000.
  // It is computed with an exact reciprocal multiply.
  localparam int FILT_SHIFT = 57;
  localparam logic [63:0] FILT_DIV = 64'd20000000;
  localparam logic [63:0] FILT_MULT_W = ((64'd1 << FILT_SHIFT) + FILT_DIV - 64'd1) / FILT_DIV;
  localparam logic [32:0] FILT_MULT = FILT_MULT_W[32:0];

  // One candidate divisor with its code.
  typedef struct packed {
    logic        found;
    logic [15:0] cand;
    logic [5:0]  code;
  } cand_t;

  // Base term of a candidate divisor.
  function automatic logic [4:0] a_val(input logic [2:0] idx);
    logic [4:0] v;
    case (idx)
      3'd0: v = 5'd10;
      3'd1: v = 5'd12;
      3'd2: v = 5'd14;
      3'd3: v = 5'd16;
      3'd4: v = 5'd18;
      3'd5: v = 5'd20;
      3'd6: v = 5'd24;
      3'd7: v = 5'd30;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

  // Divider code: g in bits 4..2, the offset base index in bits 5, 1 and 0.
  function automatic logic [5:0] div_code(input logic [2:0] idx, input logic [2:0] g);
    logic [3:0] k;
    k = {1'b0, idx} + 4'd4;
    return {k[2], g, k[1:0]};
  endfunction

  // Keep the left entry unless the right one fits and is strictly smaller.
  function automatic cand_t pick(input cand_t l, input cand_t r);
    cand_t v;
    if (r.found && (!l.found || (r.cand < l.cand))) begin
      v = r;
    end else begin
      v = l;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/icds_div.sv @@
`timescale 1ns / 1ps
module icds_div #(
  parameter int DVW = 24,
  parameter int SBW = 56
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [31:0]    in_num,
  input  logic [DVW-1:0] in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [31:0]    out_quo,
  output logic [SBW-1:0] out_sb
);

  localparam int NW = 32;
  localparam int STEPS = 2;
  localparam int NST = NW / STEPS;

  logic [NST-1:0] v_r;
  logic [DVW-1:0] rem_r [NST];
  logic [NW-1:0]  num_r [NST];
  logic [DVW-1:0] den_r [NST];
  logic [SBW-1:0] sb_r  [NST];

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_st
      logic           vi;
      logic [DVW-1:0] remi;
      logic [NW-1:0]  numi;
      logic [DVW-1:0] deni;
      logic [SBW-1:0] sbi;
      logic [DVW-1:0] rem_nxt;
      logic [NW-1:0]  num_nxt;

      // Stage input comes from the ports or the previous stage.
      if (s == 0) begin : g_first
        assign vi   = in_valid;
        assign remi = '0;
        assign numi = in_num;
        assign deni = in_den;
        assign sbi  = in_sb;
      end else begin : g_next
        assign vi   = v_r[s-1];
        assign remi = rem_r[s-1];
        assign numi = num_r[s-1];
        assign deni = den_r[s-1];
        assign sbi  = sb_r[s-1];
      end

      // Restoring division, a few quotient bits per stage.
      always_comb begin
        logic [DVW:0] t;
        logic         qb;
        rem_nxt = remi;
        num_nxt = numi;
        for (int k = 0; k < STEPS; k++) begin
          t = {rem_nxt, num_nxt[NW-1]};
          if (t >= {1'b0, deni}) begin
            rem_nxt = DVW'(t - {1'b0, deni});
            qb = 1'b1;
          end else begin
            rem_nxt = t[DVW-1:0];
            qb = 1'b0;
          end
          num_nxt = {num_nxt[NW-2:0], qb};
        end
      end

      // Valid bit of the stage.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= vi;
        end
      end

      // Payload of the stage.
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          num_r[s] <= num_nxt;
          den_r[s] <= deni;
          sb_r[s]  <= sbi;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NST-1];
  assign out_quo   = num_r[NST-1];
  assign out_sb    = sb_r[NST-1];

endmodule

@@ hw/rtl/icds_cand.sv @@
`timescale 1ns / 1ps
module icds_cand (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     in_clk_hz,
  input  logic [23:0]     in_speed,
  input  logic [15:0]     in_target,
  output logic            out_valid,
  output logic [31:0]     out_clk_hz,
  output logic [23:0]     out_speed,
  output logic [7:0]      out_filt,
  output icds_pkg::cand_t out_best
);

  import icds_pkg::*;

  // Stage 1: reciprocal multiply for the filter.
  logic        c1_v_r;
  logic [64:0] c1_prod_r;
  logic [31:0] c1_clk_r;
  logic [23:0] c1_speed_r;
  logic [15:0] c1_target_r;

  // Stage 2: all candidates and their fit flags.
  logic        c2_v_r;
  cand_t       c2_ent_r [NUM_CAND];
  logic [31:0] c2_clk_r;
  logic [23:0] c2_speed_r;
  logic [7:0]  c2_filt_r;

  // Stages 3 to 5: four-way minimum tree.
  logic        c3_v_r;
  cand_t       c3_ent_r [16];
  logic [31:0] c3_clk_r;
  logic [23:0] c3_speed_r;
  logic [7:0]  c3_filt_r;

  logic        c4_v_r;
  cand_t       c4_ent_r [4];
  logic [31:0] c4_clk_r;
  logic [23:0] c4_speed_r;
  logic [7:0]  c4_filt_r;

  logic        c5_v_r;
  cand_t       c5_ent_r;
  logic [31:0] c5_clk_r;
  logic [23:0] c5_speed_r;
  logic [7:0]  c5_filt_r;

  logic [7:0]  filt_nxt;
  cand_t       c2_ent_nxt [NUM_CAND];
  cand_t       c3_ent_nxt [16];
  cand_t       c4_ent_nxt [4];
  cand_t       c5_ent_nxt;

  // Filter value, at least one.
  always_comb begin
    filt_nxt = c1_prod_r[FILT_SHIFT +: 8];
    if (filt_nxt == 8'd0) begin
      filt_nxt = 8'd1;
    end
  end

  // Candidate divisors b*(a + 2*floor(3*filter/b)) with b = 16 << g.
  always_comb begin
    logic [9:0]  f3;
    logic [9:0]  sh;
    logic [17:0] x;
    logic [17:0] cv;
    f3 = 10'(filt_nxt) * 10'd3;
    for (int i = 0; i < NUM_A; i++) begin
      for (int g = 0; g < NUM_G; g++) begin
        sh = f3 >> (4 + g);
        x  = 18'(a_val(3'(i))) + {7'd0, sh, 1'b0};
        cv = x << (4 + g);
        c2_ent_nxt[i*NUM_G+g].cand  = cv[15:0];
        c2_ent_nxt[i*NUM_G+g].found = (cv[15:0] > c1_target_r);
        c2_ent_nxt[i*NUM_G+g].code  = div_code(3'(i), 3'(g));
      end
    end
  end

  // Minimum tree, lower index wins ties.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      c3_ent_nxt[j] = c2_ent_r[4*j];
      for (int m = 1; m < 4; m++) begin
        c3_ent_nxt[j] = pick(c3_ent_nxt[j], c2_ent_r[4*j+m]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      c4_ent_nxt[j] = c3_ent_r[4*j];
      for (int m = 1; m < 4; m++) begin
        c4_ent_nxt[j] = pick(c4_ent_nxt[j], c3_ent_r[4*j+m]);
      end
    end
    c5_ent_nxt = c4_ent_r[0];
    for (int m = 1; m < 4; m++) begin
      c5_ent_nxt = pick(c5_ent_nxt, c4_ent_r[m]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
      c5_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= in_valid;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
      c4_v_r <= c3_v_r;
      c5_v_r <= c4_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (en) begin
      c1_prod_r   <= {33'd0, in_clk_hz} * {32'd0, FILT_MULT};
      c1_clk_r    <= in_clk_hz;
      c1_speed_r  <= in_speed;
      c1_target_r <= in_target;
      c2_ent_r    <= c2_ent_nxt;
      c2_clk_r    <= c1_clk_r;
      c2_speed_r  <= c1_speed_r;
      c2_filt_r   <= filt_nxt;
      c3_ent_r    <= c3_ent_nxt;
      c3_clk_r    <= c2_clk_r;
      c3_speed_r  <= c2_speed_r;
      c3_filt_r   <= c2_filt_r;
      c4_ent_r    <= c4_ent_nxt;
      c4_clk_r    <= c3_clk_r;
      c4_speed_r  <= c3_speed_r;
      c4_filt_r   <= c3_filt_r;
      c5_ent_r    <= c5_ent_nxt;
      c5_clk_r    <= c4_clk_r;
      c5_speed_r  <= c4_speed_r;
      c5_filt_r   <= c4_filt_r;
    end
  end

  assign out_valid  = c5_v_r;
  assign out_clk_hz = c5_clk_r;
  assign out_speed  = c5_speed_r;
  assign out_filt   = c5_filt_r;
  assign out_best   = c5_ent_r;

endmodule

@@ hw/rtl/i2c_clock_divider_select.sv @@
`timescale 1ns / 1ps
// Bus clock divider selection. Each beat carries a requested bus speed; the
// block returns the filter value, the divider code, the resulting bus speed
// and a found flag, computed from the source clock register. One beat is
// accepted every cycle unless the output stalls, and results come out in order
// after two 16-stage restoring dividers (two quotient bits per stage) for
// clk/speed and clk/divisor, five stages for the filter multiply, candidate
// generation and the four-way minimum tree, and the output register. While a
// result waits on out_ready the whole pipeline holds.
module i2c_clock_divider_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_requested_speed_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_filter_value,
  output logic [5:0]  out_divider_code,
  output logic [24:0] out_actual_speed_hz,
  output logic        out_divider_found
);

  import icds_pkg::*;

  logic [31:0] clk_hz_r;
  logic        en;

  logic        ta_valid;
  logic [31:0] ta_quo;
  logic [55:0] ta_sb;
  logic [15:0] ta_target;

  logic        cd_valid;
  logic [31:0] cd_clk_hz;
  logic [23:0] cd_speed;
  logic [7:0]  cd_filt;
  cand_t       cd_best;

  logic        ac_valid;
  logic [31:0] ac_quo;
  logic [38:0] ac_sb;

  logic        out_valid_r;
  logic [7:0]  filt_r;
  logic [5:0]  code_r;
  logic [24:0] actual_r;
  logic        found_r;

  // Source clock register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  // The pipeline advances unless a result is held at the output.
  assign en = !(out_valid_r && !out_ready);
  assign in_ready = en;

  // Target divider clk/speed.
  icds_div #(.DVW(24), .SBW(56)) u_target_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_num    (clk_hz_r),
    .in_den    (in_requested_speed_hz),
    .in_sb     ({clk_hz_r, in_requested_speed_hz}),
    .out_valid (ta_valid),
    .out_quo   (ta_quo),
    .out_sb    (ta_sb)
  );

  // Saturate the target; a zero speed gives an all-ones quotient.
  assign ta_target = (ta_quo[31:16] != 16'd0) ? DIV_LIMIT : ta_quo[15:0];

  // Filter and candidate search.
  icds_cand u_cand (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (ta_valid),
    .in_clk_hz  (ta_sb[55:24]),
    .in_speed   (ta_sb[23:0]),
    .in_target  (ta_target),
    .out_valid  (cd_valid),
    .out_clk_hz (cd_clk_hz),
    .out_speed  (cd_speed),
    .out_filt   (cd_filt),
    .out_best   (cd_best)
  );

  // Actual speed clk/divisor.
  icds_div #(.DVW(16), .SBW(39)) u_actual_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cd_valid),
    .in_num    (cd_clk_hz),
    .in_den    (cd_best.cand),
    .in_sb     ({cd_speed, cd_filt, cd_best.code, cd_best.found}),
    .out_valid (ac_valid),
    .out_quo   (ac_quo),
    .out_sb    (ac_sb)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      filt_r  <= ac_sb[14:7];
      found_r <= ac_sb[0];
      if (ac_sb[0]) begin
        code_r   <= ac_sb[6:1];
        actual_r <= ac_quo[24:0];
      end else begin
        code_r   <= NOFIT_CODE;
        actual_r <= {1'b0, ac_sb[38:15]};
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filter_value    = filt_r;
  assign out_divider_code    = code_r;
  assign out_actual_speed_hz = actual_r;
  assign out_divider_found   = found_r;

  // A held result blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  // A result without a fitting divisor carries the fallback code.
  a_nofit_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (code_r == NOFIT_CODE))
    else $error("fallback code missing");

  // The filter value is never zero.
  a_filt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (filt_r != 8'd0))
    else $error("zero filter value");

endmodule

@@ bench/tb_i2c_clock_divider_select.sv @@
`timescale 1ns / 1ps
module tb_i2c_clock_divider_select;
  import icds_pkg::*;

  // Expected contents of one result beat.
  typedef struct packed {
    logic [7:0]  filter_value;
    logic [5:0]  divider_code;
    logic [24:0] actual_speed_hz;
    logic        divider_found;
  } divider_result_t;

  // Gap between the last result and a register write.
  localparam int SETTLE_CYCLES = 45;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_requested_speed_hz;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_filter_value;
  logic [5:0]  out_divider_code;
  logic [24:0] out_actual_speed_hz;
  logic        out_divider_found;

  // Source clock as the block sees it, and the work queues.
  logic [31:0]     source_clock_hz;
  logic [23:0]     speed_queue[$];
  divider_result_t expected_results[$];
  int              mismatch_count;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_off_left;
  int              cycle_count;

  i2c_clock_divider_select dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_requested_speed_hz(in_requested_speed_hz),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_filter_value(out_filter_value),
    .out_divider_code(out_divider_code),
    .out_actual_speed_hz(out_actual_speed_hz),
    .out_divider_found(out_divider_found)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Divider search over all 64 candidates for one requested speed.
  function automatic divider_result_t select_divider(input logic [31:0] src_hz,
                                                     input logic [23:0] speed_hz);
    logic [31:0]     target;
    logic [31:0]     filt;
    logic [31:0]     base;
    logic [31:0]     shift_base;
    logic [31:0]     cand;
    logic [31:0]     best;
    logic [3:0]      k;
    divider_result_t r;
    best = 32'd0;
    r.filter_value = 8'd0;
    r.divider_code = NOFIT_CODE;
    r.actual_speed_hz = {1'b0, speed_hz};
    r.divider_found = 1'b0;
    if (speed_hz == 24'd0) begin
      target = 32'd65535;
    end else begin
      target = src_hz / speed_hz;
      if (target > 32'd65535) target = 32'd65535;
    end
    filt = ((32'd5 * (src_hz / 32'd1000)) / 32'd100000) & 32'hFF;
    if (filt == 32'd0) filt = 32'd1;
    r.filter_value = filt[7:0];
    for (int i = 0; i < 8; i++) begin
      case (i)
        0: base = 32'd10;
        1: base = 32'd12;
        2: base = 32'd14;
        3: base = 32'd16;
        4: base = 32'd18;
        5: base = 32'd20;
        6: base = 32'd24;
        default: base = 32'd30;
      endcase
      k = 4'(i + 4);
      for (int g = 0; g < 8; g++) begin
        shift_base = 32'd16 << g;
        cand = shift_base * (base + ((32'd3 * filt) / shift_base) * 32'd2);
        if (cand > target && (!r.divider_found || cand < best)) begin
          r.divider_found = 1'b1;
          best = cand;
          r.divider_code = {k[2], 3'(g), k[1:0]};
          r.actual_speed_hz = 25'(src_hz / cand);
        end
      end
    end
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: offers the pending speeds, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(
          select_divider(source_clock_hz, in_requested_speed_hz));
      if (speed_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_requested_speed_hz <= speed_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat and drives the receiver stalls.
  always @(posedge clk) begin
    divider_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time,
                 {out_filter_value, out_divider_code, out_actual_speed_hz,
                  out_divider_found});
        mismatch_count = mismatch_count + 1;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.filter_value !== out_filter_value) begin
          $display("%0t: filter_value expected %0d actual %0d", $time,
                   exp_r.filter_value, out_filter_value);
          mismatch_count = mismatch_count + 1;
        end
        if (exp_r.divider_code !== out_divider_code) begin
          $display("%0t: divider_code expected %h actual %h", $time,
                   exp_r.divider_code, out_divider_code);
          mismatch_count = mismatch_count + 1;
        end
        if (exp_r.actual_speed_hz !== out_actual_speed_hz) begin
          $display("%0t: actual_speed_hz expected %0d actual %0d", $time,
                   exp_r.actual_speed_hz, out_actual_speed_hz);
          mismatch_count = mismatch_count + 1;
        end
        if (exp_r.divider_found !== out_divider_found) begin
          $display("%0t: divider_found expected %0d actual %0d", $time,
                   exp_r.divider_found, out_divider_found);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Waits until every queued speed has produced its result.
  task automatic drain_pipeline();
    while (speed_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the source clock register while the block is idle.
  task automatic write_source_clock(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    source_clock_hz = value;
  endtask

  // Random speed, mostly in the range where a divider can be found.
  function automatic logic [23:0] random_speed();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(4095));
      2: return 24'($urandom_range(1000000, 10000));
      3: return 24'($urandom_range(8000000, 1));
      default: return 24'($urandom_range(500000, 1000));
    endcase
  endfunction

  // Stimulus: directed speeds, then random phases under several clocks.
  initial begin
    logic [31:0] clocks[6];
    clocks = '{32'd199999998, 32'd0, 32'd1, 32'hFFFFFFFF, 32'd66666666,
               32'd1000000000};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    in_valid = 1'b0;
    in_requested_speed_hz = 24'd0;
    out_ready = 1'b0;
    source_clock_hz = CLK_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    hold_off_left = 0;
    send_idle_pct = 11;
    recv_idle_pct = 47;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed speeds under each of the six source clocks: zero, extremes, common rates.
    foreach (clocks[c]) begin
      if (c > 0) write_source_clock(clocks[c]);
      speed_queue.push_back(24'd0);
      speed_queue.push_back(24'd1);
      speed_queue.push_back(24'hFFFFFF);
      speed_queue.push_back(24'd100000);
      speed_queue.push_back(24'd400000);
      speed_queue.push_back(24'hAAAAAA);
      speed_queue.push_back(24'h555555);
      drain_pipeline();
    end

    // Long receiver hold-off while the sender keeps offering beats.
    write_source_clock(32'd199999998);
    for (int n = 0; n < 120; n++) speed_queue.push_back(random_speed());
    hold_off_left = 300;
    drain_pipeline();

    // Random phases, idling pattern swapped from phase 2 on and idling off from phase 4 on.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 11;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_source_clock((phase % 3 == 0) ? 32'($urandom) :
                         32'($urandom_range(600000000, 1000000)));
      for (int n = 0; n < 200; n++) speed_queue.push_back(random_speed());
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/icds_pkg.sv
hw/rtl/icds_div.sv
hw/rtl/icds_cand.sv
hw/rtl/i2c_clock_divider_select.sv
bench/tb_i2c_clock_divider_select.sv
